// ===== design/sld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

    localparam int FIXED_LENGTH_DEF = 10;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic [7:0] MARK_FIXED  = 8'hff;
    localparam logic [7:0] HEAD_FIRST  = 8'ha5;
    localparam logic [7:0] HEAD_SECOND = 8'h5a;
    localparam logic [7:0] TRAILER_AT  = 8'd3;

    localparam logic [1:0] MODE_FIXED = 2'd0;
    localparam logic [1:0] MODE_VAR   = 2'd1;

    localparam logic REG_FRAME_MODE = 1'b0;

    typedef enum logic [2:0] {
        PH_HUNT      = 3'd0,
        PH_FIX_PAY   = 3'd1,
        PH_FIX_CLOSE = 3'd2,
        PH_SAW_HEAD  = 3'd3,
        PH_LENGTH    = 3'd4,
        PH_VAR_PAY   = 3'd5,
        PH_TRAILER   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        EV_PAYLOAD   = 3'd0,
        EV_FIX_DONE  = 3'd1,
        EV_VAR_DONE  = 3'd2,
        EV_RESTART   = 3'd3,
        EV_DROP      = 3'd4
    } event_kind_t;

    typedef struct packed {
        logic        valid;
        event_kind_t kind;
        logic [7:0]  index;
        logic [7:0]  value;
    } result_t;

endpackage

`default_nettype wire

// ===== design/sensor_link_deframer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Frame recognizer for received serial bytes. Each accepted data_byte item steps the
// frame state machine once and yields at most one result item (payload byte with its
// index, frame done, restart or drop). Throughput is one item per clock while out_valid is
// not held by a low out_ready; each item waits in the input register, and the state
// machine step lands in the result register that drives out_valid. A result held at the
// output keeps the next item in the input register and the input stalls until out_ready
// returns. frame_mode at byte address 0 selects fixed 0xff-delimited frames, variable
// headed frames, or none, and is sampled only while hunting for a frame start.

module sensor_link_deframer_unit #(
    parameter int FIXED_LENGTH = sld_pkg::FIXED_LENGTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sld_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sld_pkg::PDATA_W-1:0] pwdata,
    output logic      [sld_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  data_byte,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [2:0]                  event_kind,
    output logic      [7:0]                  byte_index,
    output logic      [7:0]                  payload_value
);
    import sld_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [2:0] event_kind_reg;
    logic [7:0] byte_index_reg;
    logic [7:0] payload_value_reg;
    logic       advance;
    logic [1:0] frame_mode;
    result_t    res;

    sld_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .frame_mode (frame_mode)
    );

    sld_frame_fsm #(
        .FIXED_LENGTH (FIXED_LENGTH)
    ) u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .step_byte  (in_byte_reg),
        .frame_mode (frame_mode),
        .res        (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res.valid;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
        end
        if (advance && res.valid)
        begin
            event_kind_reg    <= res.kind;
            byte_index_reg    <= res.index;
            payload_value_reg <= res.value;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = event_kind_reg;
    assign byte_index    = byte_index_reg;
    assign payload_value = payload_value_reg;

endmodule

`default_nettype wire

// ===== design/sld_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sld_apb_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sld_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sld_pkg::PDATA_W-1:0] pwdata,
    output logic      [sld_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output logic      [1:0]                  frame_mode
);
    import sld_pkg::*;

    logic [1:0] frame_mode_reg;
    logic [1:0] frame_mode_next;
    logic       wr_frame_mode;

    assign pready        = 1'b1;
    assign wr_frame_mode = psel && penable && pwrite && (paddr[2] == REG_FRAME_MODE);

    always_comb
    begin
        frame_mode_next = frame_mode_reg;
        if (wr_frame_mode)
        begin
            frame_mode_next = pwdata[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_mode_reg <= MODE_FIXED;
        end
        else
        begin
            frame_mode_reg <= frame_mode_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_FRAME_MODE)
        begin
            prdata = {{(PDATA_W-2){1'b0}}, frame_mode_reg};
        end
    end

    assign frame_mode = frame_mode_reg;

endmodule

`default_nettype wire

// ===== design/sld_frame_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sld_frame_fsm #(
    parameter int FIXED_LENGTH = sld_pkg::FIXED_LENGTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire logic [7:0]      step_byte,
    input  wire logic [1:0]      frame_mode,
    output sld_pkg::result_t     res
);
    import sld_pkg::*;

    localparam logic [7:0] FIXED_LEN8 = 8'(FIXED_LENGTH);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] byte_count_reg;
    logic [7:0] byte_count_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            byte_count_reg <= 8'd0;
            bytes_left_reg <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        bytes_left_next = bytes_left_reg;
        res.valid       = 1'b0;
        res.kind        = EV_PAYLOAD;
        res.index       = byte_count_reg;
        res.value       = 8'd0;
        case (phase_reg)
            PH_HUNT:
            begin
                if (step_byte == MARK_FIXED && frame_mode == MODE_FIXED)
                begin
                    phase_next = PH_FIX_PAY;
                end
                else if (step_byte == HEAD_FIRST && frame_mode == MODE_VAR)
                begin
                    phase_next = PH_SAW_HEAD;
                end
                byte_count_next = 8'd0;
            end
            PH_FIX_PAY:
            begin
                if (step_byte == MARK_FIXED && byte_count_reg != FIXED_LEN8)
                begin
                    byte_count_next = 8'd0;
                    res.valid       = 1'b1;
                    res.kind        = EV_RESTART;
                end
                else if (step_byte == MARK_FIXED)
                begin
                    phase_next = PH_FIX_CLOSE;
                end
                else if (byte_count_reg > FIXED_LEN8)
                begin
                    phase_next = PH_HUNT;
                    res.valid  = 1'b1;
                    res.kind   = EV_DROP;
                end
                else
                begin
                    byte_count_next = byte_count_reg + 8'd1;
                    res.valid       = 1'b1;
                    res.value       = step_byte;
                end
            end
            PH_FIX_CLOSE:
            begin
                byte_count_next = 8'd0;
                phase_next      = PH_HUNT;
                res.valid       = 1'b1;
                res.kind        = EV_FIX_DONE;
            end
            PH_SAW_HEAD:
            begin
                phase_next = (step_byte == HEAD_SECOND) ? PH_LENGTH : PH_HUNT;
            end
            PH_LENGTH:
            begin
                bytes_left_next = step_byte;
                phase_next      = PH_VAR_PAY;
            end
            PH_VAR_PAY:
            begin
                if (bytes_left_reg == TRAILER_AT)
                begin
                    phase_next = PH_TRAILER;
                end
                else
                begin
                    byte_count_next = byte_count_reg + 8'd1;
                    bytes_left_next = bytes_left_reg - 8'd1;
                    res.valid       = 1'b1;
                    res.value       = step_byte;
                end
            end
            PH_TRAILER:
            begin
                byte_count_next = 8'd0;
                phase_next      = PH_HUNT;
                res.valid       = 1'b1;
                res.kind        = EV_VAR_DONE;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // fixed frame count never runs past one beyond the frame length
    a_fix_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FIX_PAY |-> byte_count_reg <= FIXED_LEN8 + 8'd1)
        else $error("fixed frame count out of range");

    a_drop_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.valid && res.kind == EV_DROP |=> phase_reg == PH_HUNT)
        else $error("dropped frame did not return to hunting");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (phase_reg == PH_FIX_CLOSE || phase_reg == PH_TRAILER)
        |=> phase_reg == PH_HUNT && byte_count_reg == 8'd0)
        else $error("frame completion did not clear state");

    a_close_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FIX_CLOSE |-> byte_count_reg == FIXED_LEN8)
        else $error("fixed frame closed at wrong count");

endmodule

`default_nettype wire
